// ===== hw/rtl/qs_pkg.sv =====
package qs_pkg;

    // Datapath width of the CORDIC x/y/z registers (Q2.30 with headroom)
    localparam int CW = 36;
    localparam int CORDIC_STAGES = 30;

    localparam logic [30:0] THRESH_RESET = 31'd1073736455;
    localparam logic signed [CW-1:0] ONE_Q30 = 36'sd1073741824;
    localparam logic signed [CW-1:0] PI_Q30 = 36'sd3373259426;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [CW-1:0] GAIN_INV_Q30 = 36'sd652032874;

    typedef struct packed {
        logic signed [31:0] first_c0;
        logic signed [31:0] first_c1;
        logic signed [31:0] first_c2;
        logic signed [31:0] first_c3;
        logic signed [31:0] second_c0;
        logic signed [31:0] second_c1;
        logic signed [31:0] second_c2;
        logic signed [31:0] second_c3;
        logic [30:0]        fraction;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] out_c0;
        logic signed [31:0] out_c1;
        logic signed [31:0] out_c2;
        logic signed [31:0] out_c3;
        logic               used_linear;
    } t_out_word;

    // Payload riding along the weight computation
    typedef struct packed {
        logic [3:0][31:0] p;
        logic [3:0][32:0] q;
        logic [30:0]      t;
        logic             lin;
        logic [30:0]      cc;
        logic [30:0]      s;
    } t_front;

    // Payload riding along the length computation
    typedef struct packed {
        logic [3:0][31:0] r;
        logic             zero;
        logic             lin;
    } t_back;

    function automatic logic [31:0] atan_val(input int unsigned idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'd843314856;
            1:  v = 32'd497837829;
            2:  v = 32'd263043836;
            3:  v = 32'd133525158;
            4:  v = 32'd67021686;
            5:  v = 32'd33543515;
            6:  v = 32'd16775850;
            7:  v = 32'd8388437;
            8:  v = 32'd4194282;
            9:  v = 32'd2097149;
            10: v = 32'd1048576;
            11: v = 32'd524288;
            12: v = 32'd262144;
            13: v = 32'd131072;
            14: v = 32'd65536;
            15: v = 32'd32768;
            16: v = 32'd16384;
            17: v = 32'd8192;
            18: v = 32'd4096;
            19: v = 32'd2048;
            20: v = 32'd1024;
            21: v = 32'd512;
            22: v = 32'd256;
            23: v = 32'd128;
            24: v = 32'd64;
            25: v = 32'd32;
            26: v = 32'd16;
            27: v = 32'd8;
            28: v = 32'd4;
            29: v = 32'd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/qs_sqrt.sv =====
// Pipelined floor square root, one result bit per stage
module qs_sqrt #(
    parameter int W  = 62,
    parameter int SW = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [W-1:0]        i_rad,
    input  logic [SW-1:0]       i_sb,
    output logic                o_valid,
    output logic [W/2-1:0]      o_root,
    output logic [SW-1:0]       o_sb
);
    localparam int N = W / 2;

    wire [W-1:0]  w_rem  [0:N];
    wire [W-1:0]  w_root [0:N];
    wire          w_v    [0:N];
    wire [SW-1:0] w_sb   [0:N];

    assign w_rem[0]  = i_rad;
    assign w_root[0] = '0;
    assign w_v[0]    = i_valid;
    assign w_sb[0]   = i_sb;

    for (genvar g = 0; g < N; g++) begin : g_stage
        localparam logic [W:0] B = {{W{1'b0}}, 1'b1} << (W - 2 - 2 * g);
        logic [W:0]   w_trial;
        logic         w_take;
        logic [W-1:0] n_rem;
        logic [W-1:0] n_root;
        logic [W-1:0] r_rem;
        logic [W-1:0] r_root;
        logic         r_v;
        logic [SW-1:0] r_sb;

        assign w_trial = {1'b0, w_root[g]} + B;
        assign w_take  = {1'b0, w_rem[g]} >= w_trial;
        assign n_rem   = w_take ? w_rem[g] - w_trial[W-1:0] : w_rem[g];
        assign n_root  = w_take ? (w_root[g] >> 1) + B[W-1:0] : w_root[g] >> 1;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= n_rem;
                r_root <= n_root;
                r_sb   <= w_sb[g];
            end
        end

        assign w_rem[g+1]  = r_rem;
        assign w_root[g+1] = r_root;
        assign w_v[g+1]    = r_v;
        assign w_sb[g+1]   = r_sb;
    end

    assign o_valid = w_v[N];
    assign o_root  = w_root[N][N-1:0];
    assign o_sb    = w_sb[N];

endmodule

// ===== hw/rtl/qs_div.sv =====
// Pipelined restoring divider, shared divisor, saturates to all ones on overflow
module qs_div #(
    parameter int NW    = 64,
    parameter int DW    = 31,
    parameter int QW    = 31,
    parameter int LANES = 2,
    parameter int SW    = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [LANES-1:0][NW-1:0]     i_num,
    input  logic [DW-1:0]                i_den,
    input  logic [SW-1:0]                i_sb,
    output logic                         o_valid,
    output logic [LANES-1:0][QW-1:0]     o_quo,
    output logic [SW-1:0]                o_sb
);
    localparam int XW = NW + DW + QW;

    wire [LANES-1:0][NW-1:0] w_rem [0:QW];
    wire [LANES-1:0][QW-1:0] w_quo [0:QW];
    wire [LANES-1:0]         w_ovf [0:QW];
    wire [DW-1:0]            w_den [0:QW];
    wire                     w_v   [0:QW];
    wire [SW-1:0]            w_sb  [0:QW];

    // entry stage: overflow check
    logic                    r_v0;
    logic [LANES-1:0][NW-1:0] r_num0;
    logic [LANES-1:0]        r_ovf0;
    logic [DW-1:0]           r_den0;
    logic [SW-1:0]           r_sb0;
    logic [LANES-1:0]        n_ovf0;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_ovf0[l] = (XW'(i_num[l]) >> QW) >= XW'(i_den);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num0 <= i_num;
            r_ovf0 <= n_ovf0;
            r_den0 <= i_den;
            r_sb0  <= i_sb;
        end
    end

    assign w_rem[0] = r_num0;
    assign w_quo[0] = '0;
    assign w_ovf[0] = r_ovf0;
    assign w_den[0] = r_den0;
    assign w_v[0]   = r_v0;
    assign w_sb[0]  = r_sb0;

    for (genvar g = 0; g < QW; g++) begin : g_stage
        localparam int B = QW - 1 - g;
        logic [XW-1:0]            w_dsh;
        logic [LANES-1:0][NW-1:0] n_rem;
        logic [LANES-1:0][QW-1:0] n_quo;
        logic [LANES-1:0][NW-1:0] r_rem;
        logic [LANES-1:0][QW-1:0] r_quo;
        logic [LANES-1:0]         r_ovf;
        logic [DW-1:0]            r_den;
        logic                     r_v;
        logic [SW-1:0]            r_sb;

        assign w_dsh = XW'(w_den[g]) << B;

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                n_rem[l] = w_rem[g][l];
                n_quo[l] = w_quo[g][l];
                if (XW'(w_rem[g][l]) >= w_dsh) begin
                    n_rem[l]    = w_rem[g][l] - w_dsh[NW-1:0];
                    n_quo[l][B] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_ovf <= w_ovf[g];
                r_den <= w_den[g];
                r_sb  <= w_sb[g];
            end
        end

        assign w_rem[g+1] = r_rem;
        assign w_quo[g+1] = r_quo;
        assign w_ovf[g+1] = r_ovf;
        assign w_den[g+1] = r_den;
        assign w_v[g+1]   = r_v;
        assign w_sb[g+1]  = r_sb;
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_quo[l] = w_ovf[QW][l] ? {QW{1'b1}} : w_quo[QW][l];
        end
    end

    assign o_valid = w_v[QW];
    assign o_sb    = w_sb[QW];

endmodule

// ===== hw/rtl/qs_cordic.sv =====
// Pipelined CORDIC, one micro-rotation per stage.
// VECTOR=1: drive y to zero, angle gathers in z. VECTOR=0: drive z to zero.
module qs_cordic import qs_pkg::*; #(
    parameter bit VECTOR = 1'b0,
    parameter int LANES  = 1,
    parameter int SW     = 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [LANES-1:0][CW-1:0] i_x,
    input  logic [LANES-1:0][CW-1:0] i_y,
    input  logic [LANES-1:0][CW-1:0] i_z,
    input  logic [SW-1:0]            i_sb,
    output logic                     o_valid,
    output logic [LANES-1:0][CW-1:0] o_x,
    output logic [LANES-1:0][CW-1:0] o_y,
    output logic [LANES-1:0][CW-1:0] o_z,
    output logic [SW-1:0]            o_sb
);
    localparam int N = CORDIC_STAGES;

    wire [LANES-1:0][CW-1:0] w_x [0:N];
    wire [LANES-1:0][CW-1:0] w_y [0:N];
    wire [LANES-1:0][CW-1:0] w_z [0:N];
    wire                     w_v [0:N];
    wire [SW-1:0]            w_sb [0:N];

    assign w_x[0]  = i_x;
    assign w_y[0]  = i_y;
    assign w_z[0]  = i_z;
    assign w_v[0]  = i_valid;
    assign w_sb[0] = i_sb;

    for (genvar g = 0; g < N; g++) begin : g_stage
        logic          r_v;
        logic [SW-1:0] r_sb;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sb <= w_sb[g];
            end
        end

        assign w_v[g+1]  = r_v;
        assign w_sb[g+1] = r_sb;

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic signed [CW-1:0] w_xv, w_yv, w_zv, w_xs, w_ys, w_at;
            logic                 w_up;
            logic signed [CW-1:0] n_x, n_y, n_z;
            logic signed [CW-1:0] r_x, r_y, r_z;

            assign w_xv = w_x[g][l];
            assign w_yv = w_y[g][l];
            assign w_zv = w_z[g][l];
            assign w_xs = w_xv >>> g;
            assign w_ys = w_yv >>> g;
            assign w_at = $signed({{(CW-32){1'b0}}, atan_val(g)});
            assign w_up = VECTOR ? (w_yv > 0) : (w_zv < 0);

            assign n_x = w_up ? w_xv + w_ys : w_xv - w_ys;
            assign n_y = w_up ? w_yv - w_xs : w_yv + w_xs;
            assign n_z = w_up ? w_zv + w_at : w_zv - w_at;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x <= n_x;
                    r_y <= n_y;
                    r_z <= n_z;
                end
            end

            assign w_x[g+1][l] = r_x;
            assign w_y[g+1][l] = r_y;
            assign w_z[g+1][l] = r_z;
        end
    end

    assign o_valid = w_v[N];
    assign o_x     = w_x[N];
    assign o_y     = w_y[N];
    assign o_z     = w_z[N];
    assign o_sb    = w_sb[N];

endmodule

// ===== hw/rtl/quaternion_slerp_top.sv =====
// Throughput: one word per cycle; the whole pipeline holds while the output stalls.
// Depth is set by the two square roots, two CORDIC passes (angle, then both sines
// side by side) and two dividers.
// Reset (synchronous, active low) clears all valid bits and loads the
// linear threshold with 0.999995 in Q2.30.
module quaternion_slerp_top import qs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_word    i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_word   o_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [30:0] i_cfg_data
);
    localparam int FSW = $bits(t_front);
    localparam int BSW = $bits(t_back);

    logic        w_en;
    logic [30:0] r_thr;
    logic        r_out_valid;
    t_out_word   r_out;

    assign w_en        = !r_out_valid || !i_stall;
    assign o_stall     = !w_en;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THRESH_RESET;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    // ---------------- stage A: dot product terms
    logic signed [31:0] w_p [4];
    logic signed [31:0] w_q [4];
    logic               r_a_v;
    logic signed [31:0] r_a_p [4];
    logic signed [31:0] r_a_q [4];
    logic signed [63:0] r_a_prod [4];
    logic [30:0]        r_a_t;

    assign w_p[0] = i_data.first_c0;
    assign w_p[1] = i_data.first_c1;
    assign w_p[2] = i_data.first_c2;
    assign w_p[3] = i_data.first_c3;
    assign w_q[0] = i_data.second_c0;
    assign w_q[1] = i_data.second_c1;
    assign w_q[2] = i_data.second_c2;
    assign w_q[3] = i_data.second_c3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (w_en) begin
            r_a_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                r_a_p[i]    <= w_p[i];
                r_a_q[i]    <= w_q[i];
                r_a_prod[i] <= w_p[i] * w_q[i];
            end
            r_a_t <= i_data.fraction;
        end
    end

    // ---------------- stage B: sum, sign fold, threshold
    logic signed [63:0] w_acc;
    logic signed [35:0] w_c;
    logic signed [35:0] w_cabs;
    logic               w_cneg;
    logic               r_b_v;
    logic signed [31:0] r_b_p [4];
    logic signed [32:0] r_b_q [4];
    logic [30:0]        r_b_t;
    logic               r_b_lin;
    logic [30:0]        r_b_cc;

    always_comb begin
        w_acc = '0;
        for (int i = 0; i < 4; i++) begin
            w_acc = w_acc + (r_a_prod[i] >>> 2);
        end
    end

    assign w_c    = 36'((w_acc + 64'sd134217728) >>> 28);
    assign w_cneg = w_c[35];
    assign w_cabs = w_cneg ? -w_c : w_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (w_en) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                r_b_p[i] <= r_a_p[i];
                r_b_q[i] <= w_cneg ? -33'(r_a_q[i]) : 33'(r_a_q[i]);
            end
            r_b_t   <= r_a_t;
            r_b_lin <= w_cabs > $signed({5'b0, r_thr});
            r_b_cc  <= (w_cabs > ONE_Q30) ? ONE_Q30[30:0] : w_cabs[30:0];
        end
    end

    // ---------------- stage C: 1 - c^2
    logic [61:0] w_ccsq;
    logic        r_c_v;
    logic [61:0] r_c_rad;
    t_front      r_c_sb;

    assign w_ccsq = {31'b0, r_b_cc} * {31'b0, r_b_cc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (w_en) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_rad <= (62'd1 << 60) - w_ccsq;
            for (int i = 0; i < 4; i++) begin
                r_c_sb.p[i] <= r_b_p[i];
                r_c_sb.q[i] <= r_b_q[i];
            end
            r_c_sb.t   <= r_b_t;
            r_c_sb.lin <= r_b_lin;
            r_c_sb.cc  <= r_b_cc;
            r_c_sb.s   <= '0;
        end
    end

    // ---------------- sine of the angle: sqrt(1 - c^2)
    logic            w_s_v;
    logic [30:0]     w_s_root;
    logic [FSW-1:0]  w_s_sb;
    t_front          w_s_f;
    t_front          w_ang_in;

    qs_sqrt #(.W(62), .SW(FSW)) u_sqrt_sin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_c_v),
        .i_rad   (r_c_rad),
        .i_sb    (r_c_sb),
        .o_valid (w_s_v),
        .o_root  (w_s_root),
        .o_sb    (w_s_sb)
    );

    always_comb begin
        w_s_f        = t_front'(w_s_sb);
        w_ang_in     = w_s_f;
        w_ang_in.s   = w_s_root;
        // zero sine falls back to the linear weights
        w_ang_in.lin = w_s_f.lin || (w_s_root == '0);
    end

    // ---------------- angle = atan2(s, c)
    logic                 w_g_v;
    logic [0:0][CW-1:0]   w_g_z;
    logic [FSW-1:0]       w_g_sb;

    qs_cordic #(.VECTOR(1'b1), .LANES(1), .SW(FSW)) u_cordic_ang (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s_v),
        .i_x     ({{(CW-31){1'b0}}, w_s_f.cc}),
        .i_y     ({{(CW-31){1'b0}}, w_s_root}),
        .i_z     ('0),
        .i_sb    (w_ang_in),
        .o_valid (w_g_v),
        .o_x     (),
        .o_y     (),
        .o_z     (w_g_z),
        .o_sb    (w_g_sb)
    );

    // ---------------- stage M: (1-t)*A and t*A
    t_front             w_g_f;
    logic signed [31:0] w_a;
    logic signed [31:0] w_omt;
    logic signed [31:0] w_tv;
    logic               r_m_v;
    logic signed [63:0] r_m_prod0;
    logic signed [63:0] r_m_prod1;
    t_front             r_m_sb;

    assign w_g_f = t_front'(w_g_sb);
    assign w_a   = w_g_z[0][31:0];
    assign w_tv  = $signed({1'b0, w_g_f.t});
    assign w_omt = 32'sd1073741824 - w_tv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (w_en) begin
            r_m_v <= w_g_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_prod0 <= w_omt * w_a;
            r_m_prod1 <= w_tv * w_a;
            r_m_sb    <= w_g_f;
        end
    end

    // ---------------- stage R: round and fold angles into [-pi/2, pi/2]
    logic signed [CW-1:0] w_th0, w_th1, w_rd0, w_rd1;
    logic                 r_r_v;
    logic [1:0][CW-1:0]   r_r_th;
    t_front               r_r_sb;

    assign w_th0 = CW'((r_m_prod0 + 64'sd536870912) >>> 30);
    assign w_th1 = CW'((r_m_prod1 + 64'sd536870912) >>> 30);
    assign w_rd0 = (w_th0 > HALF_PI_Q30) ? PI_Q30 - w_th0 :
                   (w_th0 < -HALF_PI_Q30) ? -PI_Q30 - w_th0 : w_th0;
    assign w_rd1 = (w_th1 > HALF_PI_Q30) ? PI_Q30 - w_th1 :
                   (w_th1 < -HALF_PI_Q30) ? -PI_Q30 - w_th1 : w_th1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_v <= 1'b0;
        end else if (w_en) begin
            r_r_v <= r_m_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r_th[0] <= w_rd0;
            r_r_th[1] <= w_rd1;
            r_r_sb    <= r_m_sb;
        end
    end

    // ---------------- sin of both angles
    logic               w_n_v;
    logic [1:0][CW-1:0] w_n_y;
    logic [FSW-1:0]     w_n_sb;

    qs_cordic #(.VECTOR(1'b0), .LANES(2), .SW(FSW)) u_cordic_sin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_r_v),
        .i_x     ({GAIN_INV_Q30, GAIN_INV_Q30}),
        .i_y     ('0),
        .i_z     (r_r_th),
        .i_sb    (r_r_sb),
        .o_valid (w_n_v),
        .o_x     (),
        .o_y     (w_n_y),
        .o_z     (),
        .o_sb    (w_n_sb)
    );

    // ---------------- stage P: weight numerators, rounding bias folded in
    t_front             w_n_f;
    logic               r_p_v;
    logic [1:0][63:0]   r_p_num;
    logic [1:0]         r_p_neg;
    t_front             r_p_sb;

    assign w_n_f = t_front'(w_n_sb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (w_en) begin
            r_p_v <= w_n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [CW-1:0] sv;
        logic [CW-1:0]        mag;
        if (w_en) begin
            for (int l = 0; l < 2; l++) begin
                sv = w_n_y[l];
                mag = sv[CW-1] ? -sv : sv;
                r_p_neg[l] <= sv[CW-1];
                r_p_num[l] <= {mag[33:0], 30'b0} + 64'(w_n_f.s >> 1);
            end
            r_p_sb <= w_n_f;
        end
    end

    // ---------------- weight divide by sinA
    logic               w_d_v;
    logic [1:0][30:0]   w_d_q;
    logic [FSW+1:0]     w_d_sb;

    qs_div #(.NW(64), .DW(31), .QW(31), .LANES(2), .SW(FSW + 2)) u_div_weight (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_p_v),
        .i_num   (r_p_num),
        .i_den   (r_p_sb.s),
        .i_sb    ({r_p_sb, r_p_neg}),
        .o_valid (w_d_v),
        .o_quo   (w_d_q),
        .o_sb    (w_d_sb)
    );

    // ---------------- stage W: select weights
    t_front             w_d_f;
    logic [1:0]         w_d_neg;
    logic signed [31:0] w_sk0, w_sk1, w_dt;
    logic               r_w_v;
    logic signed [31:0] r_w_k0, r_w_k1;
    t_front             r_w_sb;

    assign w_d_f   = t_front'(w_d_sb[FSW+1:2]);
    assign w_d_neg = w_d_sb[1:0];
    assign w_dt    = $signed({1'b0, w_d_f.t});
    assign w_sk0   = w_d_neg[0] ? -$signed({1'b0, w_d_q[0]}) : $signed({1'b0, w_d_q[0]});
    assign w_sk1   = w_d_neg[1] ? -$signed({1'b0, w_d_q[1]}) : $signed({1'b0, w_d_q[1]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_v <= 1'b0;
        end else if (w_en) begin
            r_w_v <= w_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_w_k0 <= w_d_f.lin ? 32'sd1073741824 - w_dt : w_sk0;
            r_w_k1 <= w_d_f.lin ? w_dt : w_sk1;
            r_w_sb <= w_d_f;
        end
    end

    // ---------------- stage X: blend products
    logic               r_x_v;
    logic signed [63:0] r_x_pk [4];
    logic signed [64:0] r_x_qk [4];
    logic               r_x_lin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_v <= 1'b0;
        end else if (w_en) begin
            r_x_v <= r_w_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                r_x_pk[i] <= $signed(r_w_sb.p[i]) * r_w_k0;
                r_x_qk[i] <= $signed(r_w_sb.q[i]) * r_w_k1;
            end
            r_x_lin <= r_w_sb.lin;
        end
    end

    // ---------------- stage Y: blend sum, round to Q2.30
    logic               r_y_v;
    logic signed [35:0] r_y_r [4];
    logic               r_y_lin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y_v <= 1'b0;
        end else if (w_en) begin
            r_y_v <= r_x_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                r_y_r[i] <= 36'((66'(r_x_pk[i]) + 66'(r_x_qk[i]) + 66'sd536870912) >>> 30);
            end
            r_y_lin <= r_x_lin;
        end
    end

    // ---------------- stage Z: largest magnitude
    logic [35:0]        w_abs [4];
    logic [35:0]        w_max;
    logic               r_z_v;
    logic signed [35:0] r_z_r [4];
    logic [35:0]        r_z_m;
    logic               r_z_lin;

    always_comb begin
        w_max = '0;
        for (int i = 0; i < 4; i++) begin
            w_abs[i] = r_y_r[i][35] ? 36'(-r_y_r[i]) : 36'(r_y_r[i]);
            if (w_abs[i] > w_max) begin
                w_max = w_abs[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z_v <= 1'b0;
        end else if (w_en) begin
            r_z_v <= r_y_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_z_r   <= r_y_r;
            r_z_m   <= w_max;
            r_z_lin <= r_y_lin;
        end
    end

    // ---------------- stage S: bring components below 2^31
    logic [2:0]         w_sh;
    logic               r_s_v;
    logic signed [31:0] r_s_r [4];
    logic               r_s_zero;
    logic               r_s_lin;

    always_comb begin
        w_sh = '0;
        for (int k = 1; k <= 5; k++) begin
            if (r_z_m >= (36'd1 << (30 + k))) begin
                w_sh = 3'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_v <= 1'b0;
        end else if (w_en) begin
            r_s_v <= r_z_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                r_s_r[i] <= 32'(r_z_r[i] >>> w_sh);
            end
            r_s_zero <= (r_z_m == '0);
            r_s_lin  <= r_z_lin;
        end
    end

    // ---------------- stage Q: squares
    logic               r_q_v;
    logic [63:0]        r_q_sq [4];
    t_back              r_q_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_v <= 1'b0;
        end else if (w_en) begin
            r_q_v <= r_s_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                r_q_sq[i]   <= $unsigned(64'(r_s_r[i] * r_s_r[i]));
                r_q_sb.r[i] <= r_s_r[i];
            end
            r_q_sb.zero <= r_s_zero;
            r_q_sb.lin  <= r_s_lin;
        end
    end

    // ---------------- stage U: sum of squares
    logic        r_u_v;
    logic [63:0] r_u_sum;
    t_back       r_u_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_v <= 1'b0;
        end else if (w_en) begin
            r_u_v <= r_q_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_u_sum <= r_q_sq[0] + r_q_sq[1] + r_q_sq[2] + r_q_sq[3];
            r_u_sb  <= r_q_sb;
        end
    end

    // ---------------- length
    logic           w_l_v;
    logic [31:0]    w_l_len;
    logic [BSW-1:0] w_l_sb;
    t_back          w_l_b;

    qs_sqrt #(.W(64), .SW(BSW)) u_sqrt_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_u_v),
        .i_rad   (r_u_sum),
        .i_sb    (r_u_sb),
        .o_valid (w_l_v),
        .o_root  (w_l_len),
        .o_sb    (w_l_sb)
    );

    assign w_l_b = t_back'(w_l_sb);

    // ---------------- stage O: output numerators
    logic             r_o_v;
    logic [3:0][61:0] r_o_num;
    logic [3:0]       r_o_neg;
    logic [31:0]      r_o_len;
    logic             r_o_clr;
    logic             r_o_lin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (w_en) begin
            r_o_v <= w_l_v;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [31:0] rv;
        logic [31:0]        mag;
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                rv  = w_l_b.r[i];
                // a shifted component can reach -2^31, so keep all 32 magnitude bits
                mag = rv[31] ? -rv : rv;
                r_o_neg[i] <= rv[31];
                r_o_num[i] <= {mag, 30'b0} + 62'(w_l_len >> 1);
            end
            r_o_len <= w_l_len;
            r_o_clr <= w_l_b.zero || (w_l_len == '0);
            r_o_lin <= w_l_b.lin;
        end
    end

    // ---------------- normalize
    logic             w_e_v;
    logic [3:0][31:0] w_e_q;
    logic [5:0]       w_e_sb;

    qs_div #(.NW(62), .DW(32), .QW(32), .LANES(4), .SW(6)) u_div_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_o_v),
        .i_num   (r_o_num),
        .i_den   (r_o_len),
        .i_sb    ({r_o_lin, r_o_clr, r_o_neg}),
        .o_valid (w_e_v),
        .o_quo   (w_e_q),
        .o_sb    (w_e_sb)
    );

    // ---------------- output register: clear, sign, saturate
    logic signed [31:0] w_o [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (w_e_sb[4]) begin
                w_o[i] = '0;
            end else if (w_e_sb[i]) begin
                w_o[i] = (w_e_q[i] > 32'h8000_0000) ? 32'sh8000_0000 : -$signed(w_e_q[i]);
            end else begin
                w_o[i] = (w_e_q[i] > 32'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(w_e_q[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.out_c0      <= w_o[0];
            r_out.out_c1      <= w_o[1];
            r_out.out_c2      <= w_o[2];
            r_out.out_c3      <= w_o[3];
            r_out.used_linear <= w_e_sb[5];
        end
    end

endmodule
